// File: sv/qsf_pkg.sv
// Shared types, constants and arithmetic helpers for the quad shape function evaluator.
package qsf_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int COORD_W     = 16;
  localparam int OUT_W       = 18;
  localparam int OPW         = 28;
  localparam int NQ          = 6;
  localparam int NLANE       = 3;
  localparam int NODE_W      = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [OPW-1:0] W_ONE   = OPW'(1);
  localparam logic signed [OPW-1:0] W_TWO   = OPW'(2);
  localparam logic signed [OPW-1:0] U_W     = OPW'(1) << FRAC_BITS;
  localparam logic signed [OPW-1:0] UH_W    = OPW'(1) << (FRAC_BITS - 1);
  localparam logic signed [OPW-1:0] UQ_W    = OPW'(1) << (FRAC_BITS - 2);
  localparam logic signed [OPW-1:0] SAT_MAX = OPW'(131071);
  localparam logic signed [OPW-1:0] SAT_MIN = -OPW'(131072);
  localparam logic signed [2*OPW-1:0] FMUL_RND = (2*OPW)'(1) << (FRAC_BITS - 1);

  localparam logic [1:0] KIND_BILIN  = 2'd0;
  localparam logic [1:0] KIND_SEREN  = 2'd1;
  localparam logic [1:0] KIND_BIQUAD = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] LEVEL_FIRST  = 2'd2;
  localparam logic [1:0] LEVEL_SECOND = 2'd3;

  localparam logic CFG_KIND  = 1'b0;
  localparam logic CFG_LEVEL = 1'b1;

  localparam logic [NODE_W-1:0] LAST_BILIN  = 4'd3;
  localparam logic [NODE_W-1:0] LAST_SEREN  = 4'd7;
  localparam logic [NODE_W-1:0] LAST_BIQUAD = 4'd8;

  typedef enum logic [4:0] {
    OP_ZERO, OP_R, OP_S, OP_RP, OP_RM, OP_SP, OP_SM, OP_R2, OP_S2,
    OP_RH, OP_SH, OP_RHP, OP_RHM, OP_SHP, OP_SHM, OP_RS, OP_UQ
  } opsel_t;
  localparam int NOPS = 17;

  typedef enum logic [2:0] {
    SC_ONE, SC_HALF, SC_QUARTER, SC_TWO, SC_FOUR
  } scale_t;

  typedef struct packed {
    opsel_t     x;
    opsel_t     y;
    opsel_t     z;
    logic [1:0] nmul;
    scale_t     sc;
    logic       neg;
  } qdesc_t;

  typedef struct packed {
    logic [OPW-1:0] r;
    logic [OPW-1:0] s;
    logic [OPW-1:0] r2;
    logic [OPW-1:0] s2;
    logic [OPW-1:0] rs;
    logic [1:0]     kind;
    logic [1:0]     level;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic              corr;
    logic [1:0]        level;
  } meta_t;

  // Fixed-point product, rounded to nearest with ties toward plus infinity.
  function automatic logic signed [OPW-1:0] fmul(input logic signed [OPW-1:0] a,
                                                 input logic signed [OPW-1:0] b);
    logic signed [2*OPW-1:0] p;
    p = a * b + FMUL_RND;
    return p[FRAC_BITS +: OPW];
  endfunction

  function automatic logic signed [OPW-1:0] post(input logic signed [OPW-1:0] x,
                                                 input scale_t sc, input logic neg);
    logic signed [OPW-1:0] t;
    case (sc)
      SC_HALF:    t = (x + W_ONE) >>> 1;
      SC_QUARTER: t = (x + W_TWO) >>> 2;
      SC_TWO:     t = x <<< 1;
      SC_FOUR:    t = x <<< 2;
      default:    t = x;
    endcase
    return neg ? -t : t;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [OPW-1:0] x);
    logic signed [OPW-1:0] t;
    t = x;
    if (x > SAT_MAX) t = SAT_MAX;
    if (x < SAT_MIN) t = SAT_MIN;
    return t[OUT_W-1:0];
  endfunction

  function automatic qdesc_t d0(input opsel_t x, input scale_t sc, input logic neg);
    return '{x: x, y: OP_ZERO, z: OP_ZERO, nmul: 2'd0, sc: sc, neg: neg};
  endfunction

  function automatic qdesc_t d1(input opsel_t x, input opsel_t y, input scale_t sc,
                                input logic neg);
    return '{x: x, y: y, z: OP_ZERO, nmul: 2'd1, sc: sc, neg: neg};
  endfunction

  function automatic qdesc_t d2(input opsel_t x, input opsel_t y, input opsel_t z,
                                input scale_t sc, input logic neg);
    return '{x: x, y: y, z: z, nmul: 2'd2, sc: sc, neg: neg};
  endfunction

  // Recipe of one quantity of one node: value, d/dr, d/ds, d2/drr, d2/dss, d2/drs.
  function automatic qdesc_t node_desc(input logic biq, input logic [NODE_W-1:0] node,
                                       input logic [2:0] qty);
    qdesc_t d [NQ];
    for (int i = 0; i < NQ; i++) d[i] = d0(OP_ZERO, SC_ONE, 1'b0);
    if (!biq) begin
      case (node)
        4'd0: begin
          d[0] = d1(OP_RP, OP_SP, SC_QUARTER, 1'b0); d[1] = d0(OP_SP, SC_QUARTER, 1'b0);
          d[2] = d0(OP_RP, SC_QUARTER, 1'b0);        d[5] = d0(OP_UQ, SC_ONE, 1'b0);
        end
        4'd1: begin
          d[0] = d1(OP_RM, OP_SP, SC_QUARTER, 1'b0); d[1] = d0(OP_SP, SC_QUARTER, 1'b1);
          d[2] = d0(OP_RM, SC_QUARTER, 1'b0);        d[5] = d0(OP_UQ, SC_ONE, 1'b1);
        end
        4'd2: begin
          d[0] = d1(OP_RM, OP_SM, SC_QUARTER, 1'b0); d[1] = d0(OP_SM, SC_QUARTER, 1'b1);
          d[2] = d0(OP_RM, SC_QUARTER, 1'b1);        d[5] = d0(OP_UQ, SC_ONE, 1'b0);
        end
        4'd3: begin
          d[0] = d1(OP_RP, OP_SM, SC_QUARTER, 1'b0); d[1] = d0(OP_SM, SC_QUARTER, 1'b0);
          d[2] = d0(OP_RP, SC_QUARTER, 1'b1);        d[5] = d0(OP_UQ, SC_ONE, 1'b1);
        end
        4'd4: begin
          d[0] = d1(OP_R2, OP_SP, SC_HALF, 1'b0); d[1] = d1(OP_R, OP_SP, SC_ONE, 1'b1);
          d[2] = d0(OP_R2, SC_HALF, 1'b0);        d[3] = d0(OP_SP, SC_ONE, 1'b1);
          d[5] = d0(OP_R, SC_ONE, 1'b1);
        end
        4'd5: begin
          d[0] = d1(OP_RM, OP_S2, SC_HALF, 1'b0); d[1] = d0(OP_S2, SC_HALF, 1'b1);
          d[2] = d1(OP_RM, OP_S, SC_ONE, 1'b1);   d[4] = d0(OP_RM, SC_ONE, 1'b1);
          d[5] = d0(OP_S, SC_ONE, 1'b0);
        end
        4'd6: begin
          d[0] = d1(OP_R2, OP_SM, SC_HALF, 1'b0); d[1] = d1(OP_R, OP_SM, SC_ONE, 1'b1);
          d[2] = d0(OP_R2, SC_HALF, 1'b1);        d[3] = d0(OP_SM, SC_ONE, 1'b1);
          d[5] = d0(OP_R, SC_ONE, 1'b0);
        end
        4'd7: begin
          d[0] = d1(OP_RP, OP_S2, SC_HALF, 1'b0); d[1] = d0(OP_S2, SC_HALF, 1'b0);
          d[2] = d1(OP_RP, OP_S, SC_ONE, 1'b1);   d[4] = d0(OP_RP, SC_ONE, 1'b1);
          d[5] = d0(OP_S, SC_ONE, 1'b1);
        end
        default: ;
      endcase
    end else begin
      case (node)
        4'd0: begin
          d[0] = d2(OP_RS, OP_RP, OP_SP, SC_ONE, 1'b0);
          d[1] = d2(OP_RHP, OP_SH, OP_SP, SC_ONE, 1'b0);
          d[2] = d2(OP_SHP, OP_RH, OP_RP, SC_ONE, 1'b0);
          d[3] = d1(OP_SH, OP_SP, SC_ONE, 1'b0);
          d[4] = d1(OP_RH, OP_RP, SC_ONE, 1'b0);
          d[5] = d1(OP_SHP, OP_RHP, SC_ONE, 1'b0);
        end
        4'd1: begin
          d[0] = d2(OP_RS, OP_RM, OP_SP, SC_ONE, 1'b1);
          d[1] = d2(OP_RHM, OP_SH, OP_SP, SC_ONE, 1'b0);
          d[2] = d2(OP_SHP, OP_RH, OP_RM, SC_ONE, 1'b1);
          d[3] = d1(OP_SH, OP_SP, SC_ONE, 1'b0);
          d[4] = d1(OP_RH, OP_RM, SC_ONE, 1'b1);
          d[5] = d1(OP_SHP, OP_RHM, SC_ONE, 1'b0);
        end
        4'd2: begin
          d[0] = d2(OP_RS, OP_RM, OP_SM, SC_ONE, 1'b0);
          d[1] = d2(OP_RHM, OP_SH, OP_SM, SC_ONE, 1'b1);
          d[2] = d2(OP_SHM, OP_RH, OP_RM, SC_ONE, 1'b1);
          d[3] = d1(OP_SH, OP_SM, SC_ONE, 1'b1);
          d[4] = d1(OP_RH, OP_RM, SC_ONE, 1'b1);
          d[5] = d1(OP_SHM, OP_RHM, SC_ONE, 1'b0);
        end
        4'd3: begin
          d[0] = d2(OP_RS, OP_RP, OP_SM, SC_ONE, 1'b1);
          d[1] = d2(OP_RHP, OP_SH, OP_SM, SC_ONE, 1'b1);
          d[2] = d2(OP_SHM, OP_RH, OP_RP, SC_ONE, 1'b0);
          d[3] = d1(OP_SH, OP_SM, SC_ONE, 1'b1);
          d[4] = d1(OP_RH, OP_RP, SC_ONE, 1'b0);
          d[5] = d1(OP_SHM, OP_RHP, SC_ONE, 1'b0);
        end
        4'd4: begin
          d[0] = d2(OP_SH, OP_SP, OP_R2, SC_ONE, 1'b0);
          d[1] = d2(OP_R, OP_SH, OP_SP, SC_TWO, 1'b1);
          d[2] = d1(OP_SHP, OP_R2, SC_ONE, 1'b0);
          d[3] = d1(OP_SH, OP_SP, SC_TWO, 1'b1);
          d[4] = d0(OP_R2, SC_ONE, 1'b0);
          d[5] = d1(OP_R, OP_SHP, SC_TWO, 1'b1);
        end
        4'd5: begin
          d[0] = d2(OP_RH, OP_RM, OP_S2, SC_ONE, 1'b1);
          d[1] = d1(OP_RHM, OP_S2, SC_ONE, 1'b0);
          d[2] = d2(OP_S, OP_RH, OP_RM, SC_TWO, 1'b0);
          d[3] = d0(OP_S2, SC_ONE, 1'b0);
          d[4] = d1(OP_RH, OP_RM, SC_TWO, 1'b0);
          d[5] = d1(OP_S, OP_RHM, SC_TWO, 1'b1);
        end
        4'd6: begin
          d[0] = d2(OP_SH, OP_SM, OP_R2, SC_ONE, 1'b1);
          d[1] = d2(OP_R, OP_SH, OP_SM, SC_TWO, 1'b0);
          d[2] = d1(OP_SHM, OP_R2, SC_ONE, 1'b0);
          d[3] = d1(OP_SH, OP_SM, SC_TWO, 1'b0);
          d[4] = d0(OP_R2, SC_ONE, 1'b0);
          d[5] = d1(OP_R, OP_SHM, SC_TWO, 1'b1);
        end
        4'd7: begin
          d[0] = d2(OP_RH, OP_RP, OP_S2, SC_ONE, 1'b0);
          d[1] = d1(OP_RHP, OP_S2, SC_ONE, 1'b0);
          d[2] = d2(OP_S, OP_RH, OP_RP, SC_TWO, 1'b1);
          d[3] = d0(OP_S2, SC_ONE, 1'b0);
          d[4] = d1(OP_RH, OP_RP, SC_TWO, 1'b1);
          d[5] = d1(OP_S, OP_RHP, SC_TWO, 1'b1);
        end
        4'd8: begin
          d[0] = d1(OP_R2, OP_S2, SC_ONE, 1'b0);
          d[1] = d1(OP_R, OP_S2, SC_TWO, 1'b1);
          d[2] = d1(OP_S, OP_R2, SC_TWO, 1'b1);
          d[3] = d0(OP_S2, SC_TWO, 1'b1);
          d[4] = d0(OP_R2, SC_TWO, 1'b1);
          d[5] = d1(OP_S, OP_R, SC_FOUR, 1'b0);
        end
        default: ;
      endcase
    end
    return d[qty];
  endfunction

endpackage

// File: sv/qsf_front.sv
// Input side: accepts coordinate beats, drops unknown element kinds, precomputes squares.
module qsf_front import qsf_pkg::*; (
  input  logic                      in_push,
  output logic                      in_full,
  input  logic signed [COORD_W-1:0] in_coord_r,
  input  logic signed [COORD_W-1:0] in_coord_s,
  input  logic [1:0]                kind,
  input  logic [1:0]                level,
  input  logic                      q_full,
  output logic                      wr_en,
  output item_t                     wr_item
);

  logic                  accept;
  logic signed [OPW-1:0] r, s, rh, sh;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  // An unknown element kind produces no results, so the beat is simply consumed.
  assign wr_en   = accept && (kind != KIND_NONE);

  always_comb begin
    r  = {{(OPW-COORD_W){in_coord_r[COORD_W-1]}}, in_coord_r};
    s  = {{(OPW-COORD_W){in_coord_s[COORD_W-1]}}, in_coord_s};
    rh = (r + W_ONE) >>> 1;
    sh = (s + W_ONE) >>> 1;
    wr_item.r     = r;
    wr_item.s     = s;
    wr_item.r2    = U_W - fmul(r, r);
    wr_item.s2    = U_W - fmul(s, s);
    wr_item.rs    = fmul(rh, sh);
    wr_item.kind  = kind;
    wr_item.level = level;
  end

endmodule

// File: sv/qsf_queue.sv
// Short queue of classified coordinate items between the front and back parts.
module qsf_queue import qsf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  output logic  rd_valid,
  output item_t rd_item,
  input  logic  rd_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: sv/qsf_back.sv
// Back part: node sequencer and five-stage evaluation pipeline ending in the result register.
module qsf_back import qsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [NODE_W-1:0]        out_node_index,
  output logic signed [OUT_W-1:0]  out_shape_value,
  output logic signed [OUT_W-1:0]  out_d_dr,
  output logic signed [OUT_W-1:0]  out_d_ds,
  output logic signed [OUT_W-1:0]  out_d2_drr,
  output logic signed [OUT_W-1:0]  out_d2_dss,
  output logic signed [OUT_W-1:0]  out_d2_drs,
  output logic                     out_last_node
);

  logic [NODE_W-1:0] cnt_r, cnt_nxt, last_idx;
  logic              en, issue, is_last;
  logic [NODE_W-1:0] lane_node [NLANE];
  logic signed [OPW-1:0] ops [NOPS];
  logic signed [OPW-1:0] rr, ss;
  qdesc_t            desc [NLANE][NQ];
  meta_t             meta0;

  logic signed [OPW-1:0] a1_r [NLANE][NQ];
  logic signed [OPW-1:0] b1_r [NLANE][NQ];
  logic signed [OPW-1:0] c1_r [NLANE][NQ];
  logic signed [OPW-1:0] c2_r [NLANE][NQ];
  logic signed [OPW-1:0] p2_r [NLANE][NQ];
  logic signed [OPW-1:0] p3_r [NLANE][NQ];
  logic signed [OPW-1:0] v4_r [NLANE][NQ];
  logic [1:0]            nm1_r [NLANE][NQ];
  logic [1:0]            nm2_r [NLANE][NQ];
  scale_t                sc1_r [NLANE][NQ];
  scale_t                sc2_r [NLANE][NQ];
  scale_t                sc3_r [NLANE][NQ];
  logic                  ng1_r [NLANE][NQ];
  logic                  ng2_r [NLANE][NQ];
  logic                  ng3_r [NLANE][NQ];
  logic signed [OUT_W-1:0] res5_r [NQ];
  logic signed [OPW-1:0]   fin [NQ];
  meta_t m1_r, m2_r, m3_r, m4_r, m5_r;
  logic  v1_r, v2_r, v3_r, v4_vld_r, v5_r;

  always_comb begin
    case (q_item.kind)
      KIND_BILIN: last_idx = LAST_BILIN;
      KIND_SEREN: last_idx = LAST_SEREN;
      default:    last_idx = LAST_BIQUAD;
    endcase
  end

  assign en      = !v5_r || out_pop;
  assign issue   = en && q_valid;
  assign is_last = (cnt_r == last_idx);
  assign q_pop   = issue && is_last;
  assign cnt_nxt = issue ? (is_last ? '0 : cnt_r + 1'b1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Lane 0 evaluates the node itself; lanes 1 and 2 evaluate the two adjacent
  // mid-side nodes that a serendipity corner subtracts.
  always_comb begin
    rr = $signed(q_item.r);
    ss = $signed(q_item.s);
    ops[OP_ZERO] = '0;
    ops[OP_R]    = rr;
    ops[OP_S]    = ss;
    ops[OP_RP]   = U_W + rr;
    ops[OP_RM]   = U_W - rr;
    ops[OP_SP]   = U_W + ss;
    ops[OP_SM]   = U_W - ss;
    ops[OP_R2]   = $signed(q_item.r2);
    ops[OP_S2]   = $signed(q_item.s2);
    ops[OP_RH]   = (rr + W_ONE) >>> 1;
    ops[OP_SH]   = (ss + W_ONE) >>> 1;
    ops[OP_RHP]  = rr + UH_W;
    ops[OP_RHM]  = rr - UH_W;
    ops[OP_SHP]  = ss + UH_W;
    ops[OP_SHM]  = ss - UH_W;
    ops[OP_RS]   = $signed(q_item.rs);
    ops[OP_UQ]   = UQ_W;
    lane_node[0] = cnt_r;
    lane_node[1] = {2'b01, cnt_r[1:0]};
    lane_node[2] = {2'b01, cnt_r[1:0] - 2'd1};
    for (int l = 0; l < NLANE; l++) begin
      for (int q = 0; q < NQ; q++) begin
        desc[l][q] = node_desc((l == 0) && (q_item.kind == KIND_BIQUAD), lane_node[l], 3'(q));
      end
    end
    meta0.node  = cnt_r;
    meta0.last  = is_last;
    meta0.corr  = (q_item.kind == KIND_SEREN) && !cnt_r[2];
    meta0.level = q_item.level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_vld_r <= 1'b0;
      v5_r     <= 1'b0;
    end else if (en) begin
      v1_r     <= issue;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_vld_r <= v3_r;
      v5_r     <= v4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= meta0;
      m2_r <= m1_r;
      m3_r <= m2_r;
      m4_r <= m3_r;
      m5_r <= m4_r;
      for (int l = 0; l < NLANE; l++) begin
        for (int q = 0; q < NQ; q++) begin
          a1_r[l][q]  <= ops[desc[l][q].x];
          b1_r[l][q]  <= ops[desc[l][q].y];
          c1_r[l][q]  <= ops[desc[l][q].z];
          nm1_r[l][q] <= desc[l][q].nmul;
          sc1_r[l][q] <= desc[l][q].sc;
          ng1_r[l][q] <= desc[l][q].neg;
          p2_r[l][q]  <= (nm1_r[l][q] != 2'd0) ? fmul(a1_r[l][q], b1_r[l][q]) : a1_r[l][q];
          c2_r[l][q]  <= c1_r[l][q];
          nm2_r[l][q] <= nm1_r[l][q];
          sc2_r[l][q] <= sc1_r[l][q];
          ng2_r[l][q] <= ng1_r[l][q];
          p3_r[l][q]  <= (nm2_r[l][q] == 2'd2) ? fmul(p2_r[l][q], c2_r[l][q]) : p2_r[l][q];
          sc3_r[l][q] <= sc2_r[l][q];
          ng3_r[l][q] <= ng2_r[l][q];
          v4_r[l][q]  <= post(p3_r[l][q], sc3_r[l][q], ng3_r[l][q]);
        end
      end
      for (int q = 0; q < NQ; q++) begin
        res5_r[q] <= sat(fin[q]);
      end
    end
  end

  // Corner correction for the serendipity element, then masking of derivatives
  // beyond the requested level.
  always_comb begin
    for (int q = 0; q < NQ; q++) begin
      fin[q] = v4_r[0][q];
      if (m4_r.corr) begin
        fin[q] = v4_r[0][q] - ((v4_r[1][q] + v4_r[2][q] + W_ONE) >>> 1);
      end
      if ((q == 1 || q == 2) && m4_r.level < LEVEL_FIRST) fin[q] = '0;
      if (q >= 3 && m4_r.level != LEVEL_SECOND) fin[q] = '0;
    end
  end

  assign out_empty       = !v5_r;
  assign out_node_index  = m5_r.node;
  assign out_last_node   = m5_r.last;
  assign out_shape_value = res5_r[0];
  assign out_d_dr        = res5_r[1];
  assign out_d_ds        = res5_r[2];
  assign out_d2_drr      = res5_r[3];
  assign out_d2_dss      = res5_r[4];
  assign out_d2_drs      = res5_r[5];

  a_last_node: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && m5_r.last) |->
    (m5_r.node == LAST_BILIN || m5_r.node == LAST_SEREN || m5_r.node == LAST_BIQUAD))
    else $error("last node flag on a node that ends no element");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_BIQUAD)
    else $error("node counter out of range");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_corr_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && m5_r.corr) |-> (m5_r.node < 4'd4))
    else $error("corner correction applied to a non-corner node");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !out_pop) |=> (v5_r && $stable(m5_r)))
    else $error("waiting result lost or changed");

endmodule

// File: sv/quad_shape_function_eval.sv
// Top level of the quadrilateral shape function evaluator.
//
// Usage: write element_kind (index 0) and eval_level (index 1) through the
// cfg_ write channel while the block is idle; cfg_ready is always high.
// Each input beat carries one natural coordinate pair (r, s) and is taken
// when in_push is high and in_full is low. For that pair the block emits one
// result beat per element node, in node order: 4 for the bilinear, 8 for the
// serendipity and 9 for the biquadratic element, with out_last_node marking
// the final one. An unknown element kind consumes the beat and emits nothing.
// An accepted beat is written to the queue, then its nodes pass through the
// evaluation pipeline into the result register. Results leave at one per
// cycle while the receiver keeps popping; the node sequencer issues one node
// per cycle while the pipeline is not held. A two-entry queue lets new beats
// be accepted while the previous pair is still being emitted.
// When the receiver holds off pop, the whole evaluation pipeline freezes with
// the oldest result on the out_ ports; no result is dropped or repeated.
// Reset (synchronous, active low) empties queue and pipeline and returns the
// registers to the four-node element with second derivatives enabled.
module quad_shape_function_eval import qsf_pkg::*; #(
  parameter int Q_DEPTH = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [1:0]               cfg_data,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic signed [COORD_W-1:0] in_coord_r,
  input  logic signed [COORD_W-1:0] in_coord_s,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [NODE_W-1:0]        out_node_index,
  output logic signed [OUT_W-1:0]  out_shape_value,
  output logic signed [OUT_W-1:0]  out_d_dr,
  output logic signed [OUT_W-1:0]  out_d_ds,
  output logic signed [OUT_W-1:0]  out_d2_drr,
  output logic signed [OUT_W-1:0]  out_d2_dss,
  output logic signed [OUT_W-1:0]  out_d2_drs,
  output logic                     out_last_node
);

  logic [1:0] kind_r, level_r;
  logic       q_full, q_wr, q_valid, q_pop;
  item_t      q_wr_item, q_head;

  // Configuration is a plain register write; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_BILIN;
      level_r <= LEVEL_SECOND;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KIND:  kind_r  <= cfg_data;
        CFG_LEVEL: level_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // The front snapshots both registers with every item, so each queued item
  // carries its own element kind and level down the back end.
  qsf_front u_front (
    .in_push    (in_push),
    .in_full    (in_full),
    .in_coord_r (in_coord_r),
    .in_coord_s (in_coord_s),
    .kind       (kind_r),
    .level      (level_r),
    .q_full     (q_full),
    .wr_en      (q_wr),
    .wr_item    (q_wr_item)
  );

  qsf_queue #(.DEPTH(Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_item  (q_wr_item),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_item  (q_head),
    .rd_pop   (q_pop)
  );

  // The back end walks the nodes of the head item and holds its pipeline
  // whenever the result register is occupied and not being popped.
  qsf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_node_index  (out_node_index),
    .out_shape_value (out_shape_value),
    .out_d_dr        (out_d_dr),
    .out_d_ds        (out_d_ds),
    .out_d2_drr      (out_d2_drr),
    .out_d2_dss      (out_d2_dss),
    .out_d2_drs      (out_d2_drs),
    .out_last_node   (out_last_node)
  );

endmodule
